### hdl/kf_pkg.sv
// Shared types, constants and microcode for the two-state Kalman filter step.
// Holds the datapath command/status structs, the operand address map and the program table.
// No dependencies.
`timescale 1ns / 1ps

package kf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int PC_W          = 7;
    localparam int ADDR_W        = 6;
    localparam int SCR_W         = 5;
    localparam int ROM_DEPTH     = 128;

    // Configuration register indexes.
    localparam logic [3:0] CFG_F_ROW0  = 4'd0;
    localparam logic [3:0] CFG_F_ROW1  = 4'd1;
    localparam logic [3:0] CFG_Q_ROW0  = 4'd2;
    localparam logic [3:0] CFG_Q_ROW1  = 4'd3;
    localparam logic [3:0] CFG_H_ROW   = 4'd4;
    localparam logic [3:0] CFG_R_NOISE = 4'd5;
    localparam logic [3:0] CFG_X_INIT  = 4'd6;
    localparam logic [3:0] CFG_P_INIT  = 4'd7;

    // Reset values of the configuration and state registers.
    localparam logic [63:0] F_ROW0_RST = 64'h0000_0000_0001_0000;
    localparam logic [63:0] F_ROW1_RST = 64'h0001_0000_0000_0000;
    localparam logic [63:0] H_ROW_RST  = 64'h0000_0000_0001_0000;
    localparam logic [30:0] R_RST      = 31'd65536;
    localparam logic [30:0] PINIT_RST  = 31'd65536;
    localparam logic [31:0] PDIAG_RST  = 32'd65536;

    // Operand address map: low half are fixed sources, upper half is scratch memory.
    localparam logic [5:0] A_ZERO = 6'd0;
    localparam logic [5:0] A_ONE  = 6'd1;
    localparam logic [5:0] A_F00  = 6'd2;
    localparam logic [5:0] A_F01  = 6'd3;
    localparam logic [5:0] A_F10  = 6'd4;
    localparam logic [5:0] A_F11  = 6'd5;
    localparam logic [5:0] A_Q00  = 6'd6;
    localparam logic [5:0] A_Q01  = 6'd7;
    localparam logic [5:0] A_Q10  = 6'd8;
    localparam logic [5:0] A_Q11  = 6'd9;
    localparam logic [5:0] A_H0   = 6'd10;
    localparam logic [5:0] A_H1   = 6'd11;
    localparam logic [5:0] A_R    = 6'd12;
    localparam logic [5:0] A_XI0  = 6'd13;
    localparam logic [5:0] A_XI1  = 6'd14;
    localparam logic [5:0] A_PI   = 6'd15;
    localparam logic [5:0] A_Z    = 6'd16;
    localparam logic [5:0] A_X0   = 6'd17;
    localparam logic [5:0] A_X1   = 6'd18;
    localparam logic [5:0] A_P00  = 6'd19;
    localparam logic [5:0] A_P01  = 6'd20;
    localparam logic [5:0] A_P10  = 6'd21;
    localparam logic [5:0] A_P11  = 6'd22;
    localparam logic [5:0] A_T0   = 6'd32;
    localparam logic [5:0] A_T1   = 6'd33;
    localparam logic [5:0] A_XP0  = 6'd34;
    localparam logic [5:0] A_XP1  = 6'd35;
    localparam logic [5:0] A_A00  = 6'd36;
    localparam logic [5:0] A_A01  = 6'd37;
    localparam logic [5:0] A_A10  = 6'd38;
    localparam logic [5:0] A_A11  = 6'd39;
    localparam logic [5:0] A_PP00 = 6'd40;
    localparam logic [5:0] A_PP01 = 6'd41;
    localparam logic [5:0] A_PP10 = 6'd42;
    localparam logic [5:0] A_PP11 = 6'd43;
    localparam logic [5:0] A_HX   = 6'd44;
    localparam logic [5:0] A_Y    = 6'd45;
    localparam logic [5:0] A_PH0  = 6'd46;
    localparam logic [5:0] A_PH1  = 6'd47;
    localparam logic [5:0] A_S    = 6'd48;
    localparam logic [5:0] A_K0   = 6'd49;
    localparam logic [5:0] A_K1   = 6'd50;
    localparam logic [5:0] A_M00  = 6'd51;
    localparam logic [5:0] A_M01  = 6'd52;
    localparam logic [5:0] A_M10  = 6'd53;
    localparam logic [5:0] A_M11  = 6'd54;
    localparam logic [5:0] A_C00  = 6'd55;
    localparam logic [5:0] A_C01  = 6'd56;
    localparam logic [5:0] A_C10  = 6'd57;
    localparam logic [5:0] A_C11  = 6'd58;
    localparam logic [5:0] A_KR0  = 6'd59;
    localparam logic [5:0] A_KR1  = 6'd60;
    localparam logic [5:0] A_T2   = 6'd61;
    localparam logic [5:0] A_T3   = 6'd62;

    // Program entry points.
    localparam logic [PC_W-1:0] PC_RESTART = 7'd0;
    localparam logic [PC_W-1:0] PC_SKIP    = 7'd7;
    localparam logic [PC_W-1:0] PC_MAIN    = 7'd14;

    typedef enum logic [3:0] {
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_MOV,
        OP_DIV,
        OP_BNP,
        OP_END_OK,
        OP_END_SKIP,
        OP_END_RST
    } op_kind_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_SKIP    = 2'd1,
        STAT_RESTART = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_FETCH,
        CS_EXEC,
        CS_DIV,
        CS_WRITE,
        CS_DONE
    } ctrl_state_t;

    typedef struct packed {
        op_kind_t         kind;
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
    } op_t;

    typedef struct packed {
        logic    latch;
        logic    fetch;
        logic    exec;
        logic    div_start;
        logic    wr;
        logic    cap;
        op_t     op;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic nonpos;
    } dp_sts_t;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        else begin
            return $signed(v[31:0]);
        end
    endfunction

    function automatic op_t mk(input op_kind_t k, input logic [5:0] d,
                               input logic [5:0] a, input logic [5:0] b);
        op_t o;
        o.kind = k;
        o.dst  = d;
        o.a    = a;
        o.b    = b;
        return o;
    endfunction

    // Microcode table: restart block, skip block, then the full filter step.
    function automatic op_t prog_rom(input logic [PC_W-1:0] pc);
        op_t rom [ROM_DEPTH];
        int  n;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[i] = mk(OP_END_OK, A_ZERO, A_ZERO, A_ZERO);
        end
        n = 0;
        // Restart: reload state and covariance.
        rom[n] = mk(OP_MOV, A_X0, A_XI0, A_ZERO);   n++;
        rom[n] = mk(OP_MOV, A_X1, A_XI1, A_ZERO);   n++;
        rom[n] = mk(OP_MOV, A_P00, A_PI, A_ZERO);   n++;
        rom[n] = mk(OP_MOV, A_P01, A_ZERO, A_ZERO); n++;
        rom[n] = mk(OP_MOV, A_P10, A_ZERO, A_ZERO); n++;
        rom[n] = mk(OP_MOV, A_P11, A_PI, A_ZERO);   n++;
        rom[n] = mk(OP_END_RST, A_ZERO, A_ZERO, A_ZERO); n++;
        // Skip: keep the prediction.
        rom[n] = mk(OP_MOV, A_X0, A_XP0, A_ZERO);   n++;
        rom[n] = mk(OP_MOV, A_X1, A_XP1, A_ZERO);   n++;
        rom[n] = mk(OP_MOV, A_P00, A_PP00, A_ZERO); n++;
        rom[n] = mk(OP_MOV, A_P01, A_PP01, A_ZERO); n++;
        rom[n] = mk(OP_MOV, A_P10, A_PP10, A_ZERO); n++;
        rom[n] = mk(OP_MOV, A_P11, A_PP11, A_ZERO); n++;
        rom[n] = mk(OP_END_SKIP, A_ZERO, A_ZERO, A_ZERO); n++;
        // Predicted state.
        rom[n] = mk(OP_MUL, A_T0, A_F00, A_X0);  n++;
        rom[n] = mk(OP_MUL, A_T1, A_F01, A_X1);  n++;
        rom[n] = mk(OP_ADD, A_XP0, A_T0, A_T1);  n++;
        rom[n] = mk(OP_MUL, A_T0, A_F10, A_X0);  n++;
        rom[n] = mk(OP_MUL, A_T1, A_F11, A_X1);  n++;
        rom[n] = mk(OP_ADD, A_XP1, A_T0, A_T1);  n++;
        // F P.
        rom[n] = mk(OP_MUL, A_T0, A_F00, A_P00); n++;
        rom[n] = mk(OP_MUL, A_T1, A_F01, A_P10); n++;
        rom[n] = mk(OP_ADD, A_A00, A_T0, A_T1);  n++;
        rom[n] = mk(OP_MUL, A_T0, A_F00, A_P01); n++;
        rom[n] = mk(OP_MUL, A_T1, A_F01, A_P11); n++;
        rom[n] = mk(OP_ADD, A_A01, A_T0, A_T1);  n++;
        rom[n] = mk(OP_MUL, A_T0, A_F10, A_P00); n++;
        rom[n] = mk(OP_MUL, A_T1, A_F11, A_P10); n++;
        rom[n] = mk(OP_ADD, A_A10, A_T0, A_T1);  n++;
        rom[n] = mk(OP_MUL, A_T0, A_F10, A_P01); n++;
        rom[n] = mk(OP_MUL, A_T1, A_F11, A_P11); n++;
        rom[n] = mk(OP_ADD, A_A11, A_T0, A_T1);  n++;
        // (F P) F' + Q.
        rom[n] = mk(OP_MUL, A_T0, A_A00, A_F00);   n++;
        rom[n] = mk(OP_MUL, A_T1, A_A01, A_F01);   n++;
        rom[n] = mk(OP_ADD, A_PP00, A_T0, A_T1);   n++;
        rom[n] = mk(OP_ADD, A_PP00, A_PP00, A_Q00); n++;
        rom[n] = mk(OP_MUL, A_T0, A_A00, A_F10);   n++;
        rom[n] = mk(OP_MUL, A_T1, A_A01, A_F11);   n++;
        rom[n] = mk(OP_ADD, A_PP01, A_T0, A_T1);   n++;
        rom[n] = mk(OP_ADD, A_PP01, A_PP01, A_Q01); n++;
        rom[n] = mk(OP_MUL, A_T0, A_A10, A_F00);   n++;
        rom[n] = mk(OP_MUL, A_T1, A_A11, A_F01);   n++;
        rom[n] = mk(OP_ADD, A_PP10, A_T0, A_T1);   n++;
        rom[n] = mk(OP_ADD, A_PP10, A_PP10, A_Q10); n++;
        rom[n] = mk(OP_MUL, A_T0, A_A10, A_F10);   n++;
        rom[n] = mk(OP_MUL, A_T1, A_A11, A_F11);   n++;
        rom[n] = mk(OP_ADD, A_PP11, A_T0, A_T1);   n++;
        rom[n] = mk(OP_ADD, A_PP11, A_PP11, A_Q11); n++;
        // Innovation.
        rom[n] = mk(OP_MUL, A_T0, A_H0, A_XP0);  n++;
        rom[n] = mk(OP_MUL, A_T1, A_H1, A_XP1);  n++;
        rom[n] = mk(OP_ADD, A_HX, A_T0, A_T1);   n++;
        rom[n] = mk(OP_SUB, A_Y, A_Z, A_HX);     n++;
        // P H' and S.
        rom[n] = mk(OP_MUL, A_T0, A_PP00, A_H0); n++;
        rom[n] = mk(OP_MUL, A_T1, A_PP01, A_H1); n++;
        rom[n] = mk(OP_ADD, A_PH0, A_T0, A_T1);  n++;
        rom[n] = mk(OP_MUL, A_T0, A_PP10, A_H0); n++;
        rom[n] = mk(OP_MUL, A_T1, A_PP11, A_H1); n++;
        rom[n] = mk(OP_ADD, A_PH1, A_T0, A_T1);  n++;
        rom[n] = mk(OP_MUL, A_T0, A_H0, A_PH0);  n++;
        rom[n] = mk(OP_MUL, A_T1, A_H1, A_PH1);  n++;
        rom[n] = mk(OP_ADD, A_S, A_T0, A_T1);    n++;
        rom[n] = mk(OP_ADD, A_S, A_S, A_R);      n++;
        rom[n] = mk(OP_BNP, A_ZERO, A_S, A_ZERO); n++;
        // Gain and state correction.
        rom[n] = mk(OP_DIV, A_K0, A_PH0, A_S);   n++;
        rom[n] = mk(OP_DIV, A_K1, A_PH1, A_S);   n++;
        rom[n] = mk(OP_MUL, A_T0, A_K0, A_Y);    n++;
        rom[n] = mk(OP_ADD, A_X0, A_XP0, A_T0);  n++;
        rom[n] = mk(OP_MUL, A_T0, A_K1, A_Y);    n++;
        rom[n] = mk(OP_ADD, A_X1, A_XP1, A_T0);  n++;
        // M = I - K H.
        rom[n] = mk(OP_MUL, A_T0, A_K0, A_H0);   n++;
        rom[n] = mk(OP_SUB, A_M00, A_ONE, A_T0); n++;
        rom[n] = mk(OP_MUL, A_T0, A_K0, A_H1);   n++;
        rom[n] = mk(OP_SUB, A_M01, A_ZERO, A_T0); n++;
        rom[n] = mk(OP_MUL, A_T0, A_K1, A_H0);   n++;
        rom[n] = mk(OP_SUB, A_M10, A_ZERO, A_T0); n++;
        rom[n] = mk(OP_MUL, A_T0, A_K1, A_H1);   n++;
        rom[n] = mk(OP_SUB, A_M11, A_ONE, A_T0); n++;
        // C = M P.
        rom[n] = mk(OP_MUL, A_T0, A_M00, A_PP00); n++;
        rom[n] = mk(OP_MUL, A_T1, A_M01, A_PP10); n++;
        rom[n] = mk(OP_ADD, A_C00, A_T0, A_T1);   n++;
        rom[n] = mk(OP_MUL, A_T0, A_M00, A_PP01); n++;
        rom[n] = mk(OP_MUL, A_T1, A_M01, A_PP11); n++;
        rom[n] = mk(OP_ADD, A_C01, A_T0, A_T1);   n++;
        rom[n] = mk(OP_MUL, A_T0, A_M10, A_PP00); n++;
        rom[n] = mk(OP_MUL, A_T1, A_M11, A_PP10); n++;
        rom[n] = mk(OP_ADD, A_C10, A_T0, A_T1);   n++;
        rom[n] = mk(OP_MUL, A_T0, A_M10, A_PP01); n++;
        rom[n] = mk(OP_MUL, A_T1, A_M11, A_PP11); n++;
        rom[n] = mk(OP_ADD, A_C11, A_T0, A_T1);   n++;
        // K R.
        rom[n] = mk(OP_MUL, A_KR0, A_K0, A_R);   n++;
        rom[n] = mk(OP_MUL, A_KR1, A_K1, A_R);   n++;
        // P = C M' + (K R) K'.
        rom[n] = mk(OP_MUL, A_T0, A_C00, A_M00); n++;
        rom[n] = mk(OP_MUL, A_T1, A_C01, A_M01); n++;
        rom[n] = mk(OP_ADD, A_T2, A_T0, A_T1);   n++;
        rom[n] = mk(OP_MUL, A_T3, A_KR0, A_K0);  n++;
        rom[n] = mk(OP_ADD, A_P00, A_T2, A_T3);  n++;
        rom[n] = mk(OP_MUL, A_T0, A_C00, A_M10); n++;
        rom[n] = mk(OP_MUL, A_T1, A_C01, A_M11); n++;
        rom[n] = mk(OP_ADD, A_T2, A_T0, A_T1);   n++;
        rom[n] = mk(OP_MUL, A_T3, A_KR0, A_K1);  n++;
        rom[n] = mk(OP_ADD, A_P01, A_T2, A_T3);  n++;
        rom[n] = mk(OP_MUL, A_T0, A_C10, A_M00); n++;
        rom[n] = mk(OP_MUL, A_T1, A_C11, A_M01); n++;
        rom[n] = mk(OP_ADD, A_T2, A_T0, A_T1);   n++;
        rom[n] = mk(OP_MUL, A_T3, A_KR1, A_K0);  n++;
        rom[n] = mk(OP_ADD, A_P10, A_T2, A_T3);  n++;
        rom[n] = mk(OP_MUL, A_T0, A_C10, A_M10); n++;
        rom[n] = mk(OP_MUL, A_T1, A_C11, A_M11); n++;
        rom[n] = mk(OP_ADD, A_T2, A_T0, A_T1);   n++;
        rom[n] = mk(OP_MUL, A_T3, A_KR1, A_K1);  n++;
        rom[n] = mk(OP_ADD, A_P11, A_T2, A_T3);  n++;
        rom[n] = mk(OP_END_OK, A_ZERO, A_ZERO, A_ZERO);
        return rom[pc];
    endfunction

endpackage

### hdl/kf_div.sv
// Bit-serial signed divider producing (num * 2^FRAC_BITS) / den, truncated toward zero.
// Stands alone with no package dependency; the denominator must be positive.
`timescale 1ns / 1ps

module kf_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [63:0] quot
);
    localparam int NW    = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    work_reg;
    logic [31:0]      den_reg;
    logic [31:0]      rem_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [31:0]      num_mag;
    logic [32:0]      rem_sh;
    logic             fits;

    assign num_mag = num[31] ? 32'(-num) : 32'(num);
    assign rem_sh  = {rem_reg, work_reg[NW-1]};
    assign fits    = rem_sh >= {1'b0, den_reg};

    // Control: one quotient bit per cycle.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Restoring shift-subtract datapath; quotient bits shift into the numerator register.
    // The remainder stays below the denominator, so 32 bits hold it.
    always_ff @(posedge clk) begin
        if (start) begin
            work_reg <= {num_mag, {FRAC_BITS{1'b0}}};
            den_reg  <= den;
            rem_reg  <= '0;
            neg_reg  <= num[31];
        end
        else if (busy_reg) begin
            rem_reg  <= fits ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            work_reg <= {work_reg[NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(64'(work_reg)) : $signed(64'(work_reg));

endmodule

### hdl/kf_datapath.sv
// Datapath: configuration registers, filter state, scratch memory, shared multiply/add unit.
// Depends on kf_pkg and kf_div.
`timescale 1ns / 1ps

module kf_datapath #(
    parameter int FRAC_BITS = kf_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    input  logic [3:0]      cfg_index,
    input  logic [63:0]     cfg_data,
    input  logic [31:0]     measurement,
    input  kf_pkg::dp_cmd_t cmd,
    output kf_pkg::dp_sts_t sts,
    output logic [191:0]    out_data,
    output logic [1:0]      out_status
);
    import kf_pkg::*;

    localparam logic [31:0] ONE_C = 32'd1 << FRAC_BITS;

    logic [63:0] f_row0_reg, f_row1_reg, q_row0_reg, q_row1_reg, h_row_reg, x_init_reg;
    logic [30:0] r_reg, pinit_reg;
    logic [31:0] x0_reg, x1_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic [31:0] z_reg;
    logic [31:0] mem [2**SCR_W];
    logic [31:0] mem_a_reg, mem_b_reg, src_a_reg, src_b_reg;
    logic        sel_a_reg, sel_b_reg;
    logic signed [31:0] opa, opb;
    logic signed [63:0] prod;
    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_next;
    logic signed [31:0] wb_val;
    logic signed [63:0] div_q;
    logic               div_done;
    logic [191:0]       out_data_reg;
    logic [1:0]         out_status_reg;

    // Fixed operand sources.
    function automatic logic [31:0] src_val(input logic [ADDR_W-1:0] addr);
        logic [31:0] v;
        unique case (addr)
            A_ONE:   v = ONE_C;
            A_F00:   v = f_row0_reg[31:0];
            A_F01:   v = f_row0_reg[63:32];
            A_F10:   v = f_row1_reg[31:0];
            A_F11:   v = f_row1_reg[63:32];
            A_Q00:   v = q_row0_reg[31:0];
            A_Q01:   v = q_row0_reg[63:32];
            A_Q10:   v = q_row1_reg[31:0];
            A_Q11:   v = q_row1_reg[63:32];
            A_H0:    v = h_row_reg[31:0];
            A_H1:    v = h_row_reg[63:32];
            A_R:     v = {1'b0, r_reg};
            A_XI0:   v = x_init_reg[31:0];
            A_XI1:   v = x_init_reg[63:32];
            A_PI:    v = {1'b0, pinit_reg};
            A_Z:     v = z_reg;
            A_X0:    v = x0_reg;
            A_X1:    v = x1_reg;
            A_P00:   v = p00_reg;
            A_P01:   v = p01_reg;
            A_P10:   v = p10_reg;
            A_P11:   v = p11_reg;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            f_row0_reg <= F_ROW0_RST;
            f_row1_reg <= F_ROW1_RST;
            q_row0_reg <= '0;
            q_row1_reg <= '0;
            h_row_reg  <= H_ROW_RST;
            r_reg      <= R_RST;
            x_init_reg <= '0;
            pinit_reg  <= PINIT_RST;
        end
        else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_F_ROW0:  f_row0_reg <= cfg_data;
                CFG_F_ROW1:  f_row1_reg <= cfg_data;
                CFG_Q_ROW0:  q_row0_reg <= cfg_data;
                CFG_Q_ROW1:  q_row1_reg <= cfg_data;
                CFG_H_ROW:   h_row_reg  <= cfg_data;
                CFG_R_NOISE: r_reg      <= cfg_data[30:0];
                CFG_X_INIT:  x_init_reg <= cfg_data;
                CFG_P_INIT:  pinit_reg  <= cfg_data[30:0];
                default:     ;
            endcase
        end
    end

    // Filter state, written back by the program.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            x0_reg  <= '0;
            x1_reg  <= '0;
            p00_reg <= PDIAG_RST;
            p01_reg <= '0;
            p10_reg <= '0;
            p11_reg <= PDIAG_RST;
        end
        else if (cmd.wr && !cmd.op.dst[ADDR_W-1]) begin
            unique case (cmd.op.dst)
                A_X0:    x0_reg  <= wb_val;
                A_X1:    x1_reg  <= wb_val;
                A_P00:   p00_reg <= wb_val;
                A_P01:   p01_reg <= wb_val;
                A_P10:   p10_reg <= wb_val;
                A_P11:   p11_reg <= wb_val;
                default: ;
            endcase
        end
    end

    // Scratch memory: one write port, two registered read ports.
    always_ff @(posedge clk) begin
        if (cmd.wr && cmd.op.dst[ADDR_W-1]) begin
            mem[cmd.op.dst[SCR_W-1:0]] <= wb_val;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.fetch) begin
            mem_a_reg <= mem[cmd.op.a[SCR_W-1:0]];
            mem_b_reg <= mem[cmd.op.b[SCR_W-1:0]];
            src_a_reg <= src_val(cmd.op.a);
            src_b_reg <= src_val(cmd.op.b);
            sel_a_reg <= cmd.op.a[ADDR_W-1];
            sel_b_reg <= cmd.op.b[ADDR_W-1];
        end
        if (cmd.latch) begin
            z_reg <= measurement;
        end
    end

    assign opa  = $signed(sel_a_reg ? mem_a_reg : src_a_reg);
    assign opb  = $signed(sel_b_reg ? mem_b_reg : src_b_reg);
    assign prod = opa * opb;

    // Execute: product, sum, difference or the first operand passed through into the accumulator.
    always_comb begin
        case (cmd.op.kind)
            OP_MUL:  acc_next = prod;
            OP_ADD:  acc_next = 64'(opa) + 64'(opb);
            OP_SUB:  acc_next = 64'(opa) - 64'(opb);
            default: acc_next = 64'(opa);
        endcase
    end

    always_ff @(posedge clk) begin
        if (cmd.exec) begin
            acc_reg <= acc_next;
        end
    end

    kf_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (opa),
        .den   (opb),
        .done  (div_done),
        .quot  (div_q)
    );

    // Write-back value: products drop the fraction by flooring, everything saturates.
    always_comb begin
        case (cmd.op.kind)
            OP_MUL:  wb_val = sat32(acc_reg >>> FRAC_BITS);
            OP_DIV:  wb_val = sat32(div_q);
            default: wb_val = sat32(acc_reg);
        endcase
    end

    // Result register.
    always_ff @(posedge clk) begin
        if (cmd.cap) begin
            out_data_reg   <= {p11_reg, p10_reg, p01_reg, p00_reg, x1_reg, x0_reg};
            out_status_reg <= cmd.status;
        end
    end

    assign sts.div_done = div_done;
    assign sts.nonpos   = (acc_reg <= 64'sd0);
    assign out_data     = out_data_reg;
    assign out_status   = out_status_reg;

endmodule

### hdl/kf_ctrl.sv
// Controller: program counter and state machine that sequence the datapath microcode.
// Depends on kf_pkg.
`timescale 1ns / 1ps

module kf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            s_tuser,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output kf_pkg::dp_cmd_t cmd,
    input  kf_pkg::dp_sts_t sts
);
    import kf_pkg::*;

    ctrl_state_t     state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            out_valid_reg, out_valid_next;
    op_t             op;

    assign op = prog_rom(pc_reg);

    // State, program counter and result-valid registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= CS_IDLE;
            pc_reg        <= PC_MAIN;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        cmd            = '0;
        cmd.op         = op;
        cmd.status     = STAT_OK;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            CS_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    pc_next    = s_tuser ? PC_RESTART : PC_MAIN;
                    state_next = CS_FETCH;
                end
            end
            CS_FETCH: begin
                if (op.kind == OP_END_OK || op.kind == OP_END_SKIP ||
                    op.kind == OP_END_RST) begin
                    state_next = CS_DONE;
                end
                else begin
                    cmd.fetch  = 1'b1;
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC: begin
                cmd.exec = 1'b1;
                if (op.kind == OP_DIV) begin
                    cmd.div_start = 1'b1;
                    state_next    = CS_DIV;
                end
                else begin
                    state_next = CS_WRITE;
                end
            end
            CS_DIV: begin
                if (sts.div_done) begin
                    state_next = CS_WRITE;
                end
            end
            CS_WRITE: begin
                if (op.kind == OP_BNP) begin
                    pc_next = sts.nonpos ? PC_SKIP : pc_reg + 1'b1;
                end
                else begin
                    cmd.wr  = 1'b1;
                    pc_next = pc_reg + 1'b1;
                end
                state_next = CS_FETCH;
            end
            CS_DONE: begin
                case (op.kind)
                    OP_END_SKIP: cmd.status = STAT_SKIP;
                    OP_END_RST:  cmd.status = STAT_RESTART;
                    default:     cmd.status = STAT_OK;
                endcase
                // Hand off only when the result register is free or being emptied.
                if (!out_valid_reg || m_tready) begin
                    cmd.cap        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

### hdl/kalman_filter_step.sv
// Top level of the two-state, one-measurement Kalman filter step.
// Depends on kf_pkg, kf_ctrl, kf_datapath (and kf_div below it).
`timescale 1ns / 1ps

// One transfer on the s_ side either filters a Q16.16 measurement (predict, innovation,
// gain, correction, Joseph-form covariance update) or, with s_tuser set, reloads x_init
// and p_init times identity; each gives one result transfer with the new state, the
// covariance and a status code. The block works on one item at a time. A step whose
// innovation variance is not positive keeps the prediction. The microcode sequencer runs
// each multiply, add or move through the single shared multiply/add unit in its fetch,
// execute and write states, and the bit-serial divider is used twice for the gain. A
// finished result waits in its own register, so the next item is taken while it is still
// unread. Configuration must be written by the user through the cfg_ port only while the
// block is idle; the block itself does not enforce this. cfg_ready is always high.
module kalman_filter_step #(
    parameter int FRAC_BITS = kf_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] measurement
    input  logic         s_tuser,   // [0] restart
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // est_state0, est_state1, cov00, cov01, cov10, cov11
    output logic [1:0]   m_tuser,   // [1:0] status
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import kf_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    kf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    kf_datapath #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .measurement (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .out_data    (m_tdata),
        .out_status  (m_tuser)
    );

    // Only one datapath phase is commanded in any cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.latch, cmd.fetch, cmd.exec, cmd.wr, cmd.cap}))
        else $error("more than one datapath phase commanded");

    // After an input transfer the block is busy until the result is captured.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a step is in progress");

    // A captured result never carries an undefined status code.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cap |=> (m_tvalid && m_tuser != 2'd3))
        else $error("result captured with bad status");

endmodule
